FILE: rtl/core/pgct_pkg.sv
// ----------------------------------------------------------------------------
// pgct_pkg
// shared types, constants and a distance-squaring helper for the peer goal claim table
// ----------------------------------------------------------------------------
package pgct_pkg;

    localparam int MAX_PEERS = 8;
    localparam int IDX_W     = $clog2(MAX_PEERS);
    localparam int CNT_W     = $clog2(MAX_PEERS + 1);

    localparam logic [1:0] KIND_INTENT = 2'd0;
    localparam logic [1:0] KIND_PRUNE  = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_OWN    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [7:0]  peer;
        logic [31:0] goal;
        logic [31:0] robot;
        logic [31:0] expiry;
    } entry_t;

    // per-step command broadcast to the cells
    typedef struct packed {
        logic        shift;
        logic        write;
        logic [IDX_W-1:0] wr_idx;
        entry_t      wr_data;
    } cell_ctl_t;

    // square of a signed coordinate difference
    function automatic logic [33:0] sq17(logic signed [16:0] v);
        logic signed [33:0] p;
        p = v * v;
        return p;
    endfunction

endpackage

FILE: rtl/core/pgct_cell.sv
// ----------------------------------------------------------------------------
// pgct_cell
// one table slot: holds an entry, shifts toward head or takes a write
// ----------------------------------------------------------------------------
module pgct_cell (
    input  logic                        clk,
    input  logic [pgct_pkg::IDX_W-1:0]  slot,
    input  pgct_pkg::cell_ctl_t         ctl,
    input  pgct_pkg::entry_t            shift_data,
    output pgct_pkg::entry_t            data
);
    import pgct_pkg::*;

    entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.write && ctl.wr_idx == slot)
        begin
            data_reg <= ctl.wr_data;
        end
        else if (ctl.shift)
        begin
            data_reg <= shift_data;
        end
    end

    assign data = data_reg;

endmodule

FILE: rtl/core/peer_goal_claim_table.sv
// ----------------------------------------------------------------------------
// peer_goal_claim_table
// table of latest peer goal claims with intent, prune and match query requests
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  request  | start / busy       | kind peer_id point_x/y pos_x/y time_ms ttl_ms match_radius
//  result   | done strobe        | status found match_id self_wins entry_count
//  config   | cfg_valid/cfg_ready| cfg_data (self_id)
//
//  a request accepted while idle runs the scan state, which steps through every
//  slot popping the head cell and writing kept entries back at the queue tail,
//  then the self state to form the result, then the done state with done high.
//  busy stays high through the done state, so a new request is taken only
//  after done. the receiver cannot stall. reset clears count and self_id.
// ----------------------------------------------------------------------------
module peer_goal_claim_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  peer_id,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [31:0] time_ms,
    input  logic [15:0] ttl_ms,
    input  logic [14:0] match_radius,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic        found,
    output logic [7:0]  match_id,
    output logic        self_wins,
    output logic [3:0]  entry_count
);
    import pgct_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_SELF = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  self_id_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] qlen_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  pid_reg;
    logic signed [15:0] cx_reg, cy_reg, sx_reg, sy_reg;
    logic [31:0] time_reg, exp_reg;
    logic [29:0] r2_reg;
    logic        hit_reg, have_reg;
    logic [33:0] best_reg;
    logic [7:0]  best_id_reg;
    logic [1:0]  status_reg;
    logic        found_reg, wins_reg, done_reg;
    logic [7:0]  mid_reg;

    entry_t cell_q    [MAX_PEERS];
    entry_t shift_src [MAX_PEERS];
    cell_ctl_t ctl;

    // head cell is popped each scan step; kept entries go back at the queue tail
    entry_t head;
    entry_t new_e;
    logic   in_range, keep, repl, append;
    logic signed [16:0] gdx, gdy, rdx, rdy;
    logic [33:0] gd2, rd2;

    assign head     = cell_q[0];
    assign in_range = step_reg < cnt_reg;
    assign gdx = 17'(signed'(head.goal[31:16])) - 17'(cx_reg);
    assign gdy = 17'(signed'(head.goal[15:0])) - 17'(cy_reg);
    assign rdx = 17'(signed'(head.robot[31:16])) - 17'(cx_reg);
    assign rdy = 17'(signed'(head.robot[15:0])) - 17'(cy_reg);
    assign gd2 = sq17(gdx) + sq17(gdy);
    assign rd2 = sq17(rdx) + sq17(rdy);
    assign keep = !(kind_reg == KIND_PRUNE && head.expiry <= time_reg);
    assign repl = kind_reg == KIND_INTENT && pid_reg != self_id_reg
                  && head.peer == pid_reg;
    assign append = state_reg == S_SELF && kind_reg == KIND_INTENT
                    && pid_reg != self_id_reg && !hit_reg
                    && cnt_reg != CNT_W'(MAX_PEERS);

    assign new_e = '{peer: pid_reg, goal: {cx_reg, cy_reg},
                     robot: {sx_reg, sy_reg}, expiry: exp_reg};

    always_comb
    begin
        ctl = '0;
        if (state_reg == S_SCAN && in_range)
        begin
            ctl.shift   = 1'b1;
            ctl.write   = keep;
            ctl.wr_idx  = IDX_W'(qlen_reg - 1'b1);
            ctl.wr_data = repl ? new_e : head;
        end
        else if (append)
        begin
            ctl.write   = 1'b1;
            ctl.wr_idx  = IDX_W'(cnt_reg);
            ctl.wr_data = new_e;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_PEERS; g++)
        begin : g_cells
            if (g == MAX_PEERS - 1)
            begin : g_tail
                assign shift_src[g] = cell_q[g];
            end
            else
            begin : g_body
                assign shift_src[g] = cell_q[g+1];
            end
            pgct_cell u_cell (
                .clk        (clk),
                .slot       (IDX_W'(g)),
                .ctl        (ctl),
                .shift_data (shift_src[g]),
                .data       (cell_q[g])
            );
        end
    endgenerate

    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = state_reg == S_IDLE && !start;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (step_reg == CNT_W'(MAX_PEERS - 1))
                begin
                    state_next = S_SELF;
                end
            end
            S_SELF:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    logic [33:0] self_d2;
    logic signed [16:0] sdx, sdy;
    assign sdx = 17'(sx_reg) - 17'(cx_reg);
    assign sdy = 17'(sy_reg) - 17'(cy_reg);
    assign self_d2 = sq17(sdx) + sq17(sdy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            self_id_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == S_SELF;
            if (cfg_valid && cfg_ready)
            begin
                self_id_reg <= cfg_data;
            end
            if (state_reg == S_SELF && kind_reg == KIND_PRUNE)
            begin
                cnt_reg <= qlen_reg;
            end
            else if (append)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            kind_reg <= kind;
            pid_reg  <= peer_id;
            cx_reg   <= point_x;
            cy_reg   <= point_y;
            sx_reg   <= pos_x;
            sy_reg   <= pos_y;
            time_reg <= time_ms;
            exp_reg  <= (33'(time_ms) + 33'(ttl_ms) > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF
                        : time_ms + 32'(ttl_ms);
            r2_reg   <= 30'(match_radius) * 30'(match_radius);
            step_reg <= '0;
            qlen_reg <= cnt_reg;
            hit_reg  <= 1'b0;
            have_reg <= 1'b0;
        end
        if (state_reg == S_SCAN)
        begin
            step_reg <= step_reg + 1'b1;
            if (in_range && !keep)
            begin
                qlen_reg <= qlen_reg - 1'b1;
            end
            if (in_range && head.peer == pid_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (in_range && kind_reg == KIND_QUERY && gd2 <= 34'(r2_reg)
                && (!have_reg || rd2 < best_reg))
            begin
                have_reg    <= 1'b1;
                best_reg    <= rd2;
                best_id_reg <= head.peer;
            end
        end
        if (state_reg == S_SELF)
        begin
            status_reg <= ST_DONE;
            found_reg  <= 1'b0;
            mid_reg    <= '0;
            wins_reg   <= 1'b0;
            if (kind_reg == KIND_INTENT)
            begin
                if (pid_reg == self_id_reg)
                begin
                    status_reg <= ST_OWN;
                end
                else if (!hit_reg && cnt_reg == CNT_W'(MAX_PEERS))
                begin
                    status_reg <= ST_FULL;
                end
            end
            else if (kind_reg == KIND_QUERY && have_reg)
            begin
                found_reg <= 1'b1;
                mid_reg   <= best_id_reg;
                wins_reg  <= (self_d2 < best_reg) ||
                             (self_d2 == best_reg && self_id_reg < best_id_reg);
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign match_id    = mid_reg;
    assign self_wins   = wins_reg;
    assign entry_count = 4'(cnt_reg);

    a_done_after_self: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SELF) |=> done) else $error("done missing");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_PEERS)) else $error("count overflow");
    a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready) else $error("cfg while busy");

endmodule

FILE: tb/tb_peer_goal_claim_table.sv
// ----------------------------------------------------------------------------
// tb_peer_goal_claim_table
// checks the claim table against its own software copy: intent, prune and
// query requests with random pacing, several self_id settings in between
// ----------------------------------------------------------------------------
module tb_peer_goal_claim_table;
    timeunit 1ns;
    timeprecision 1ps;

    import pgct_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  peer_id;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0] time_ms;
        logic [15:0] ttl_ms;
        logic [14:0] match_radius;
    } claim_req_t;

    typedef struct {
        logic [1:0] status;
        logic       found;
        logic [7:0] match_id;
        logic       self_wins;
        logic [3:0] entry_count;
    } claim_resp_t;

    class claim_scoreboard;
        logic [7:0]  own_id;
        logic [7:0]  peer_tab[MAX_PEERS];
        logic [15:0] gx_tab[MAX_PEERS];
        logic [15:0] gy_tab[MAX_PEERS];
        logic [15:0] rx_tab[MAX_PEERS];
        logic [15:0] ry_tab[MAX_PEERS];
        logic [31:0] exp_tab[MAX_PEERS];
        int          held;
        claim_resp_t pending[$];
        int          errors;
        int          checked;

        function new();
            own_id = 0;
            held = 0;
            errors = 0;
            checked = 0;
        endfunction

        function longint sqdist(logic signed [15:0] ax, logic signed [15:0] ay,
                                logic signed [15:0] bx, logic signed [15:0] by);
            longint dx;
            longint dy;
            dx = longint'(ax) - longint'(bx);
            dy = longint'(ay) - longint'(by);
            return dx * dx + dy * dy;
        endfunction

        function void note_request(claim_req_t r);
            claim_resp_t e;
            longint sum;
            longint rad2;
            longint best;
            longint pd;
            longint ds;
            int slot;
            int w;
            int bi;
            bit have;
            e = '{ST_DONE, 1'b0, 8'd0, 1'b0, 4'd0};
            if (r.kind == KIND_INTENT) begin
                if (r.peer_id == own_id) e.status = ST_OWN;
                else begin
                    slot = held;
                    for (int i = 0; i < held; i++)
                        if (peer_tab[i] == r.peer_id && slot == held) slot = i;
                    if (slot >= MAX_PEERS) e.status = ST_FULL;
                    else begin
                        sum = longint'(r.time_ms) + longint'(r.ttl_ms);
                        if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
                        peer_tab[slot] = r.peer_id;
                        gx_tab[slot] = r.point_x;
                        gy_tab[slot] = r.point_y;
                        rx_tab[slot] = r.pos_x;
                        ry_tab[slot] = r.pos_y;
                        exp_tab[slot] = sum[31:0];
                        if (slot == held) held++;
                    end
                end
            end else if (r.kind == KIND_PRUNE) begin
                w = 0;
                for (int i = 0; i < held; i++) begin
                    if (exp_tab[i] > r.time_ms) begin
                        peer_tab[w] = peer_tab[i];
                        gx_tab[w] = gx_tab[i];
                        gy_tab[w] = gy_tab[i];
                        rx_tab[w] = rx_tab[i];
                        ry_tab[w] = ry_tab[i];
                        exp_tab[w] = exp_tab[i];
                        w++;
                    end
                end
                held = w;
            end else if (r.kind == KIND_QUERY) begin
                rad2 = longint'(r.match_radius) * longint'(r.match_radius);
                have = 0;
                best = 0;
                bi = 0;
                for (int i = 0; i < held; i++) begin
                    if (sqdist(gx_tab[i], gy_tab[i], r.point_x, r.point_y) <= rad2) begin
                        pd = sqdist(rx_tab[i], ry_tab[i], r.point_x, r.point_y);
                        if (!have || pd < best) begin
                            have = 1;
                            best = pd;
                            bi = i;
                        end
                    end
                end
                if (have) begin
                    ds = sqdist(r.pos_x, r.pos_y, r.point_x, r.point_y);
                    e.found = 1;
                    e.match_id = peer_tab[bi];
                    if (ds < best) e.self_wins = 1;
                    else if (ds > best) e.self_wins = 0;
                    else e.self_wins = (own_id < peer_tab[bi]);
                end
            end
            e.entry_count = held[3:0];
            pending = {pending, e};
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     checked, what, got, want);
            errors++;
        endtask

        task check_result(claim_resp_t g);
            claim_resp_t e;
            if (pending.size() == 0) begin
                $display("unexpected result with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (g.status !== e.status) report_mismatch("status", g.status, e.status);
            if (g.found !== e.found) report_mismatch("found", g.found, e.found);
            if (g.match_id !== e.match_id) report_mismatch("match_id", g.match_id, e.match_id);
            if (g.self_wins !== e.self_wins)
                report_mismatch("self_wins", g.self_wins, e.self_wins);
            if (g.entry_count !== e.entry_count)
                report_mismatch("entry_count", g.entry_count, e.entry_count);
            checked++;
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  kind = 0;
    logic [7:0]  peer_id = 0;
    logic signed [15:0] point_x = 0;
    logic signed [15:0] point_y = 0;
    logic signed [15:0] pos_x = 0;
    logic signed [15:0] pos_y = 0;
    logic [31:0] time_ms = 0;
    logic [15:0] ttl_ms = 0;
    logic [14:0] match_radius = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 0;
    logic        done;
    logic [1:0]  status;
    logic        found;
    logic [7:0]  match_id;
    logic        self_wins;
    logic [3:0]  entry_count;

    claim_scoreboard sb = new();
    int idle_cycles = 0;
    int n_intent = 0;
    int n_prune = 0;
    int n_query = 0;
    int n_found = 0;
    logic [31:0] clock_ms = 32'd1000;

    always #6 clk = ~clk;

    peer_goal_claim_table u_top (.*);

    always @(posedge clk) begin
        if (done) begin
            sb.check_result('{status, found, match_id, self_wins, entry_count});
            if (found) n_found++;
        end
        if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_request(claim_req_t r);
        @(posedge clk);
        repeat ($urandom_range(0, 8)) @(posedge clk);
        start <= 1;
        kind <= r.kind;
        peer_id <= r.peer_id;
        point_x <= r.point_x;
        point_y <= r.point_y;
        pos_x <= r.pos_x;
        pos_y <= r.pos_y;
        time_ms <= r.time_ms;
        ttl_ms <= r.ttl_ms;
        match_radius <= r.match_radius;
        forever begin
            @(negedge clk);
            if (!busy) break;
        end
        @(posedge clk);
        sb.note_request(r);
        case (r.kind)
            KIND_INTENT: n_intent++;
            KIND_PRUNE:  n_prune++;
            KIND_QUERY:  n_query++;
            default: ;
        endcase
        start <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (MAX_PEERS + 6) @(posedge clk);
    endtask

    task automatic write_self_id(logic [7:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.own_id = v;
        cfg_valid <= 0;
    endtask

    function automatic claim_req_t make_req(logic [1:0] k);
        claim_req_t r;
        r.kind = k;
        r.peer_id = 8'($urandom_range(0, 11));
        r.point_x = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                             : 16'($urandom_range(0, 1200) - 600);
        r.point_y = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                             : 16'($urandom_range(0, 1200) - 600);
        r.pos_x = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                           : 16'($urandom_range(0, 1200) - 600);
        r.pos_y = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                           : 16'($urandom_range(0, 1200) - 600);
        r.ttl_ms = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 400));
        r.match_radius = $urandom_range(0, 7) == 0 ? 15'($urandom) : 15'($urandom_range(0, 700));
        if (k == KIND_PRUNE) clock_ms = clock_ms + $urandom_range(0, 200);
        r.time_ms = $urandom_range(0, 15) == 0 ? $urandom : clock_ms;
        if ($urandom_range(0, 4) == 0) r.peer_id = 8'($urandom);
        return r;
    endfunction

    initial begin
        claim_req_t r;
        logic [1:0] k;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: own intent, extremes, saturation, full table, boundaries
        r = '{KIND_INTENT, 8'd0, 16'sh7FFF, -16'sd32768, -16'sd32768, 16'sh7FFF,
              32'hFFFF_FFF0, 16'hFFFF, 15'h7FFF};
        send_request(r);
        r.peer_id = 8'd255;
        send_request(r);
        for (int i = 1; i <= 9; i++) begin
            r = '{KIND_INTENT, 8'(i), 16'(i * 10), 16'sd0, 16'(i * 20), 16'sd5,
                  32'd100, 16'(i), 15'd0};
            send_request(r);
        end
        r = '{KIND_QUERY, 8'd0, 16'sd30, 16'sd0, 16'sd0, 16'sd0, 32'd0, 16'd0, 15'd20};
        send_request(r);
        r = '{KIND_QUERY, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd0, 16'd0, 15'h7FFF};
        send_request(r);
        r = '{KIND_QUERY, 8'd0, -16'sd32768, 16'sh7FFF, 16'sh7FFF, -16'sd32768,
              32'd0, 16'd0, 15'd0};
        send_request(r);
        r = '{KIND_INTENT, 8'd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd100, 16'd3, 15'd0};
        send_request(r);
        r = '{KIND_PRUNE, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd103, 16'd0, 15'd0};
        send_request(r);
        r = '{2'd3, 8'hFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FFFF, 16'hFFFF, 15'h7FFF};
        send_request(r);
        // equal distance tie against self id
        write_self_id(8'd2);
        r = '{KIND_INTENT, 8'd7, 16'sd0, 16'sd0, 16'sd50, 16'sd0, 32'd0, 16'd999, 15'd0};
        send_request(r);
        r = '{KIND_INTENT, 8'd1, 16'sd0, 16'sd0, 16'sd0, -16'sd50, 32'd0, 16'd999, 15'd0};
        send_request(r);
        r = '{KIND_QUERY, 8'd0, 16'sd0, 16'sd0, -16'sd50, 16'sd0, 32'd0, 16'd0, 15'd0};
        send_request(r);
        r = '{KIND_PRUNE, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FFFF, 16'd0, 15'd0};
        send_request(r);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_self_id(8'd255);
                1: write_self_id(8'd0);
                2: write_self_id(8'($urandom_range(1, 11)));
                default: write_self_id(8'd5);
            endcase
            for (int n = 0; n < 160; n++) begin
                k = $urandom_range(0, 9) < 5 ? KIND_INTENT :
                    ($urandom_range(0, 5) == 0 ? KIND_PRUNE : KIND_QUERY);
                if ($urandom_range(0, 60) == 0) k = 2'd3;
                send_request(make_req(k));
                if ($urandom_range(0, 40) == 0) drain();
            end
        end

        drain();
        $display("covered %0d intents, %0d prunes, %0d queries (%0d matched)",
                 n_intent, n_prune, n_query, n_found);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
